// ===== design/fcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and constants for the frame content classifier: register
// indexes, class codes, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package fcc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_EVERY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIT_THRESHOLD = 3'd4;

    // Class codes
    localparam logic [2:0] CLASS_BLACK = 3'd0;
    localparam logic [2:0] CLASS_DARK  = 3'd1;
    localparam logic [2:0] CLASS_IMAGE = 3'd2;
    localparam logic [2:0] CLASS_FLAT  = 3'd3;
    localparam logic [2:0] CLASS_NONE  = 3'd4;

    // Geometry and field widths
    localparam int WINDOW_COUNT = 5;
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int ORG_W   = 14;
    localparam int HIT_W   = 3;
    localparam int LUMA_W  = 16;
    localparam int CNT_W   = 11;
    localparam int SUM_W   = 27;
    localparam int SQ_W    = 43;
    localparam int FRAME_W = 32;
    localparam int PHASE_W = 16;
    localparam int MUL_W   = 27;
    localparam int PROD_W  = 54;
    localparam int CMP_W   = 55;

    // Reset values of the configuration registers
    localparam logic [15:0]      RST_SAMPLE_EVERY  = 16'd120;
    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH   = 13'd1920;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT  = 13'd1080;
    localparam logic [7:0]       RST_LIT_THRESHOLD = 8'd32;

    typedef struct packed {
        logic             enable;
        logic [15:0]      sample_every;
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic [7:0]       lit_threshold;
    } t_cfg;

    // Operand select of the shared multiplier
    typedef enum logic [2:0] {
        MUL_LUMA,
        MUL_SUM,
        MUL_COUNT,
        MUL_SQ_LO,
        MUL_SQ_HI
    } t_mul_sel;

    typedef struct packed {
        logic     take;
        logic     calc;
        logic     acc_step;
        logic     frame_end;
        logic     load_b;
        logic     load_bc;
        logic     load_alo;
        logic     out_load;
        t_mul_sel mul_sel;
    } t_cmd;

    typedef struct packed {
        logic hits_zero;
        logic sample_due;
        logic out_busy;
    } t_stat;

endpackage

// ===== design/frame_content_classifier.sv =====
// ----------------------------------------------------------------------------
// frame_content_classifier
// Samples window statistics of a pixel stream and classifies sampled frames
// as black, dark, image, flat or unread.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       tdata: pixel, tlast: frame end
//   m_axis    out        m_axis_tvalid/tready       tdata: statistics, tuser: class
//   cfg       in         i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
// Each pixel is tested against the windows, squared, and then takes one
// accumulator add per window that holds it (0 to 5). A frame end that
// samples then forms the variance terms through the one shared 27x27
// multiplier, and waits while the previous result is not taken.
// Reset is synchronous; accumulators, counters and registers return to their
// defaults. The output register lets the next pixel enter while a result waits.
// ----------------------------------------------------------------------------
module frame_content_classifier
    import fcc_pkg::*;
#(
    parameter int WINDOW_SIDE = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [11:0] pixel_x, [23:12] pixel_y, [31:24] red, [39:32] green,
    // [47:40] blue
    input  logic [47:0]           s_axis_tdata,
    input  logic                  s_axis_tlast,
    // classification results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] frame_number, [42:32] lit_count, [53:43] pixel_count,
    // [80:54] luma_total, [123:81] luma_square_total, [127:124] zero
    output logic [127:0]          m_axis_tdata,
    // [2:0] class_code
    output logic [2:0]            m_axis_tuser,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    logic [FRAME_W-1:0] frame_number;
    logic [CNT_W-1:0]   lit_count;
    logic [CNT_W-1:0]   pixel_count;
    logic [SUM_W-1:0]   luma_total;
    logic [SQ_W-1:0]    luma_square_total;

    fcc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fcc_dpath #(
        .WINDOW_SIDE (WINDOW_SIDE)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (cfg),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_pixel_x           (s_axis_tdata[11:0]),
        .i_pixel_y           (s_axis_tdata[23:12]),
        .i_red               (s_axis_tdata[31:24]),
        .i_green             (s_axis_tdata[39:32]),
        .i_blue              (s_axis_tdata[47:40]),
        .i_frame_end         (s_axis_tlast),
        .o_out_valid         (m_axis_tvalid),
        .i_out_ready         (m_axis_tready),
        .o_frame_number      (frame_number),
        .o_class_code        (m_axis_tuser),
        .o_lit_count         (lit_count),
        .o_pixel_count       (pixel_count),
        .o_luma_total        (luma_total),
        .o_luma_square_total (luma_square_total)
    );

    // Pack the result fields, lowest first
    assign m_axis_tdata = {4'b0, luma_square_total, luma_total, pixel_count,
                           lit_count, frame_number};

endmodule

// ===== design/fcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fcc_cfg_regs
// Configuration register file, written through an index/data request channel.
// ----------------------------------------------------------------------------
module fcc_cfg_regs
    import fcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Store a write request; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= 1'b0;
            r_cfg.sample_every  <= RST_SAMPLE_EVERY;
            r_cfg.frame_width   <= RST_FRAME_WIDTH;
            r_cfg.frame_height  <= RST_FRAME_HEIGHT;
            r_cfg.lit_threshold <= RST_LIT_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ENABLE:        r_cfg.enable        <= i_cfg_data[0];
                REG_SAMPLE_EVERY:  r_cfg.sample_every  <= i_cfg_data;
                REG_FRAME_WIDTH:   r_cfg.frame_width   <= i_cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT:  r_cfg.frame_height  <= i_cfg_data[DIM_W-1:0];
                REG_LIT_THRESHOLD: r_cfg.lit_threshold <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== design/fcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcc_ctrl
// Sequencer: steps each pixel through window test, squaring and serial
// accumulation, then runs the frame-end classification on sampled frames.
// ----------------------------------------------------------------------------
module fcc_ctrl
    import fcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_HIT,
        S_SQ,
        S_ACC,
        S_END,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_CLS
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Decode commands and next state
    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_LUMA;
        n_state       = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_HIT;
                end
            end
            S_HIT: begin
                o_cmd.calc = 1'b1;
                n_state    = S_SQ;
            end
            S_SQ: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                if (i_stat.hits_zero) begin
                    n_state = S_END;
                end else begin
                    o_cmd.acc_step = 1'b1;
                end
            end
            S_END: begin
                o_cmd.frame_end = 1'b1;
                n_state = i_stat.sample_due ? S_M0 : S_IDLE;
            end
            S_M0: begin
                o_cmd.mul_sel = MUL_SUM;
                n_state       = S_M1;
            end
            S_M1: begin
                o_cmd.mul_sel = MUL_COUNT;
                o_cmd.load_b  = 1'b1;
                n_state       = S_M2;
            end
            S_M2: begin
                o_cmd.mul_sel = MUL_SQ_LO;
                o_cmd.load_bc = 1'b1;
                n_state       = S_M3;
            end
            S_M3: begin
                o_cmd.mul_sel  = MUL_SQ_HI;
                o_cmd.load_alo = 1'b1;
                n_state        = S_CLS;
            end
            S_CLS: begin
                o_cmd.mul_sel = MUL_SQ_HI;
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/fcc_dpath.sv =====
// ----------------------------------------------------------------------------
// fcc_dpath
// Datapath: window placement, luma, saturating accumulators, frame and phase
// counters, shared multiplier for the variance test, and the result register.
// ----------------------------------------------------------------------------
module fcc_dpath
    import fcc_pkg::*;
#(
    parameter int WINDOW_SIDE = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [COORD_W-1:0] i_pixel_x,
    input  logic [COORD_W-1:0] i_pixel_y,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    input  logic               i_frame_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [FRAME_W-1:0] o_frame_number,
    output logic [2:0]         o_class_code,
    output logic [CNT_W-1:0]   o_lit_count,
    output logic [CNT_W-1:0]   o_pixel_count,
    output logic [SUM_W-1:0]   o_luma_total,
    output logic [SQ_W-1:0]    o_luma_square_total
);

    localparam logic [ORG_W-1:0] SIDE = ORG_W'(WINDOW_SIDE);
    localparam logic [ORG_W-1:0] HALF = ORG_W'(WINDOW_SIDE / 2);

    // Negative origins clamp to zero
    function automatic logic [ORG_W-1:0] clamp_org(input logic [ORG_W:0] v);
        return v[ORG_W] ? '0 : v[ORG_W-1:0];
    endfunction

    // Latched pixel
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [7:0]         r_red;
    logic [7:0]         r_green;
    logic [7:0]         r_blue;
    logic               r_last;

    // Window geometry
    logic [ORG_W-1:0] r_wx     [WINDOW_COUNT];
    logic [ORG_W-1:0] r_wy     [WINDOW_COUNT];
    logic [ORG_W-1:0] r_wx_end [WINDOW_COUNT];
    logic [ORG_W-1:0] r_wy_end [WINDOW_COUNT];
    logic             r_fit    [WINDOW_COUNT];
    logic [ORG_W-1:0] n_wx     [WINDOW_COUNT];
    logic [ORG_W-1:0] n_wy     [WINDOW_COUNT];
    logic             n_fit    [WINDOW_COUNT];

    // Per-pixel values
    logic [LUMA_W-1:0] r_luma;
    logic              r_lit_px;
    logic [HIT_W-1:0]  r_hits;
    logic [LUMA_W-1:0] n_luma;
    logic [HIT_W-1:0]  n_hits;

    // Accumulators and counters
    logic [CNT_W-1:0]   r_lit_acc;
    logic [CNT_W-1:0]   r_pix_acc;
    logic [SUM_W-1:0]   r_luma_acc;
    logic [SQ_W-1:0]    r_sq_acc;
    logic [PHASE_W-1:0] r_phase;
    logic [FRAME_W-1:0] r_frame_cnt;

    // Multiplier and variance terms
    logic [MUL_W-1:0]  n_op_a;
    logic [MUL_W-1:0]  n_op_b;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_b;
    logic [CMP_W-1:0]  r_bc;
    logic [32:0]       r_alo;

    // Result register
    logic               r_out_valid;
    logic [FRAME_W-1:0] r_out_frame;
    logic [2:0]         r_out_class;
    logic [CNT_W-1:0]   r_out_lit;
    logic [CNT_W-1:0]   r_out_pix;
    logic [SUM_W-1:0]   r_out_luma;
    logic [SQ_W-1:0]    r_out_sq;

    // Window origins and fit from the frame size
    logic [ORG_W:0] w_lo;
    logic [ORG_W:0] w_hi;
    logic [ORG_W:0] w_mid;
    logic [ORG_W:0] h_lo;
    logic [ORG_W:0] h_hi;
    logic [ORG_W:0] h_mid;

    always_comb begin
        w_lo  = {5'b0, i_cfg.frame_width[DIM_W-1:3]};
        w_hi  = {2'b0, i_cfg.frame_width} - w_lo - {1'b0, SIDE};
        w_mid = {3'b0, i_cfg.frame_width[DIM_W-1:1]} - {1'b0, HALF};
        h_lo  = {5'b0, i_cfg.frame_height[DIM_W-1:3]};
        h_hi  = {2'b0, i_cfg.frame_height} - h_lo - {1'b0, SIDE};
        h_mid = {3'b0, i_cfg.frame_height[DIM_W-1:1]} - {1'b0, HALF};
        n_wx[0] = clamp_org(w_lo);  n_wy[0] = clamp_org(h_lo);
        n_wx[1] = clamp_org(w_hi);  n_wy[1] = clamp_org(h_lo);
        n_wx[2] = clamp_org(w_lo);  n_wy[2] = clamp_org(h_hi);
        n_wx[3] = clamp_org(w_hi);  n_wy[3] = clamp_org(h_hi);
        n_wx[4] = clamp_org(w_mid); n_wy[4] = clamp_org(h_mid);
        for (int i = 0; i < WINDOW_COUNT; i++) begin
            n_fit[i] = ((n_wx[i] + SIDE) <= {1'b0, i_cfg.frame_width})
                    && ((n_wy[i] + SIDE) <= {1'b0, i_cfg.frame_height});
        end
    end

    // Track geometry every cycle; it settles before the next pixel is tested
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < WINDOW_COUNT; i++) begin
            r_wx[i]     <= n_wx[i];
            r_wy[i]     <= n_wy[i];
            r_wx_end[i] <= n_wx[i] + SIDE;
            r_wy_end[i] <= n_wy[i] + SIDE;
            r_fit[i]    <= n_fit[i];
        end
    end

    // Luma and window hit count of the latched pixel
    logic [ORG_W-1:0] x_ext;
    logic [ORG_W-1:0] y_ext;

    always_comb begin
        x_ext  = {2'b0, r_x};
        y_ext  = {2'b0, r_y};
        n_luma = {8'b0, r_red} * 16'd77 + {8'b0, r_green} * 16'd150
               + {8'b0, r_blue} * 16'd29;
        n_hits = '0;
        for (int i = 0; i < WINDOW_COUNT; i++) begin
            if (r_fit[i] && x_ext >= r_wx[i] && x_ext < r_wx_end[i]
                    && y_ext >= r_wy[i] && y_ext < r_wy_end[i]) begin
                n_hits = n_hits + 1'b1;
            end
        end
    end

    // Shared multiplier operand select
    always_comb begin
        n_op_a = {11'b0, r_luma};
        n_op_b = {11'b0, r_luma};
        case (i_cmd.mul_sel)
            MUL_LUMA: begin
                n_op_a = {11'b0, r_luma};
                n_op_b = {11'b0, r_luma};
            end
            MUL_SUM: begin
                n_op_a = r_luma_acc;
                n_op_b = r_luma_acc;
            end
            MUL_COUNT: begin
                n_op_a = {16'b0, r_pix_acc};
                n_op_b = {16'b0, r_pix_acc};
            end
            MUL_SQ_LO: begin
                n_op_a = {16'b0, r_pix_acc};
                n_op_b = {5'b0, r_sq_acc[21:0]};
            end
            MUL_SQ_HI: begin
                n_op_a = {16'b0, r_pix_acc};
                n_op_b = {6'b0, r_sq_acc[SQ_W-1:22]};
            end
            default: begin
            end
        endcase
    end

    // Saturating sums
    logic [CNT_W:0] sum_pix;
    logic [CNT_W:0] sum_lit;
    logic [SUM_W:0] sum_luma;
    logic [SQ_W:0]  sum_sq;

    always_comb begin
        sum_pix  = {1'b0, r_pix_acc} + 1'b1;
        sum_lit  = {1'b0, r_lit_acc} + 1'b1;
        sum_luma = {1'b0, r_luma_acc} + {12'b0, r_luma};
        sum_sq   = {1'b0, r_sq_acc} + {12'b0, r_prod[31:0]};
    end

    // Sampling phase test
    logic [PHASE_W:0] every;
    logic [PHASE_W:0] phase_inc;
    logic             wrap;

    always_comb begin
        every     = (i_cfg.sample_every == '0) ? 17'd1 : {1'b0, i_cfg.sample_every};
        phase_inc = {1'b0, r_phase} + 1'b1;
        wrap      = !(phase_inc < every);
    end

    // Classification
    logic [27:0]      nn36;
    logic [CMP_W-1:0] a_full;
    logic [15:0]      lit20;
    logic [17:0]      lit100;
    logic             bright;
    logic             flat;
    logic [2:0]       n_class;

    always_comb begin
        nn36   = {1'b0, r_prod[21:0], 5'b0} + {4'b0, r_prod[21:0], 2'b0};
        a_full = {22'b0, r_alo} + {1'b0, r_prod[31:0], 22'b0};
        lit20  = {1'b0, r_lit_acc, 4'b0} + {3'b0, r_lit_acc, 2'b0};
        lit100 = {1'b0, r_lit_acc, 6'b0} + {2'b0, r_lit_acc, 5'b0}
               + {5'b0, r_lit_acc, 2'b0};
        bright = (lit20 >= {5'b0, r_pix_acc});
        flat   = (a_full < r_bc);
        if (r_pix_acc == '0) begin
            n_class = CLASS_NONE;
        end else if (bright && flat) begin
            n_class = CLASS_FLAT;
        end else if (bright) begin
            n_class = CLASS_IMAGE;
        end else if (lit100 < {7'b0, r_pix_acc}) begin
            n_class = CLASS_BLACK;
        end else begin
            n_class = CLASS_DARK;
        end
    end

    // Latch pixel, per-pixel values and variance terms
    always_ff @(posedge i_clk) begin
        r_prod <= n_op_a * n_op_b;
        if (i_cmd.take) begin
            r_x     <= i_pixel_x;
            r_y     <= i_pixel_y;
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_last  <= i_frame_end;
        end
        if (i_cmd.calc) begin
            r_luma   <= n_luma;
            r_lit_px <= (n_luma > {i_cfg.lit_threshold, 8'h00});
        end
        if (i_cmd.load_b) begin
            r_b <= r_prod;
        end
        if (i_cmd.load_bc) begin
            r_bc <= {1'b0, r_b} + {11'b0, nn36, 16'b0};
        end
        if (i_cmd.load_alo) begin
            r_alo <= r_prod[32:0];
        end
    end

    // Advance accumulators, hit counter and frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits      <= '0;
            r_lit_acc   <= '0;
            r_pix_acc   <= '0;
            r_luma_acc  <= '0;
            r_sq_acc    <= '0;
            r_phase     <= '0;
            r_frame_cnt <= '0;
        end else begin
            if (i_cmd.calc) begin
                r_hits <= i_cfg.enable ? n_hits : '0;
            end
            if (i_cmd.acc_step) begin
                r_hits     <= r_hits - 1'b1;
                r_pix_acc  <= sum_pix[CNT_W] ? '1 : sum_pix[CNT_W-1:0];
                r_luma_acc <= sum_luma[SUM_W] ? '1 : sum_luma[SUM_W-1:0];
                r_sq_acc   <= sum_sq[SQ_W] ? '1 : sum_sq[SQ_W-1:0];
                if (r_lit_px) begin
                    r_lit_acc <= sum_lit[CNT_W] ? '1 : sum_lit[CNT_W-1:0];
                end
            end
            if (i_cmd.frame_end && r_last) begin
                if (!i_cfg.enable) begin
                    r_lit_acc  <= '0;
                    r_pix_acc  <= '0;
                    r_luma_acc <= '0;
                    r_sq_acc   <= '0;
                end else begin
                    r_frame_cnt <= r_frame_cnt + 1'b1;
                    if (!wrap) begin
                        r_phase    <= phase_inc[PHASE_W-1:0];
                        r_lit_acc  <= '0;
                        r_pix_acc  <= '0;
                        r_luma_acc <= '0;
                        r_sq_acc   <= '0;
                    end else begin
                        r_phase <= '0;
                    end
                end
            end
            if (i_cmd.out_load) begin
                r_lit_acc  <= '0;
                r_pix_acc  <= '0;
                r_luma_acc <= '0;
                r_sq_acc   <= '0;
            end
        end
    end

    // Result register: hold until the request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_frame <= r_frame_cnt;
            r_out_class <= n_class;
            r_out_lit   <= r_lit_acc;
            r_out_pix   <= r_pix_acc;
            r_out_luma  <= r_luma_acc;
            r_out_sq    <= r_sq_acc;
        end
    end

    assign o_stat.hits_zero  = (r_hits == '0);
    assign o_stat.sample_due = r_last && i_cfg.enable && wrap;
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid         = r_out_valid;
    assign o_frame_number      = r_out_frame;
    assign o_class_code        = r_out_class;
    assign o_lit_count         = r_out_lit;
    assign o_pixel_count       = r_out_pix;
    assign o_luma_total        = r_out_luma;
    assign o_luma_square_total = r_out_sq;

endmodule

// ===== test/tb_frame_content_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_frame_content_classifier
// Streams pixel frames into the classifier and checks every frame statistics
// result against a cycle-free model of the window sums, frame sampling and
// classification. Directed cases come first, then a saturating frame, a long
// output hold-off, randomized frames under random configuration, and a final
// stretch at full rate on both sides.
// ----------------------------------------------------------------------------
module tb_frame_content_classifier;
    import fcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE          = 16;
    localparam int SETTLE_CYCLES = 40;   // longest pixel plus a sampled frame end
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_UNTIL  = 1200;
    localparam int QUIET_ITEMS   = 150;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic        last;
    } t_pixel;

    typedef struct packed {
        logic [31:0] frame_number;
        logic [2:0]  class_code;
        logic [10:0] lit_count;
        logic [10:0] pixel_count;
        logic [26:0] luma_total;
        logic [42:0] luma_square_total;
    } t_frame_stats;

    localparam longint unsigned CAP11 = 64'h7FF;
    localparam longint unsigned CAP27 = 64'h7FF_FFFF;
    localparam longint unsigned CAP43 = 64'h7FF_FFFF_FFFF;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [127:0]          m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    frame_content_classifier #(
        .WINDOW_SIDE(SIDE)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Model state: registers, frame sampling and window sums
    logic             cfg_en;
    logic [15:0]      cfg_every;
    logic [DIM_W-1:0] cfg_w;
    logic [DIM_W-1:0] cfg_h;
    logic [7:0]       cfg_thr;
    logic [15:0]      phase;
    logic [31:0]      frame_count;
    longint unsigned  acc_lit;
    longint unsigned  acc_pix;
    longint unsigned  acc_luma;
    longint unsigned  acc_sq;

    t_frame_stats stats_due[$];

    int  fail_count;
    int  pixels_sent;
    int  frames_ended;
    int  frames_sampled;
    int  stats_checked;
    int  class_seen[5];
    bit  idle_on;
    bit  hold_req;
    bit  pix_offered;

    // Place window i from the current frame size; report whether it fits
    function automatic bit window_place(input int i, output int wx, output int wy);
        int w;
        int h;
        int ox;
        int oy;
        w = int'(cfg_w);
        h = int'(cfg_h);
        case (i)
            0: begin ox = w / 8;            oy = h / 8; end
            1: begin ox = w - w / 8 - SIDE; oy = h / 8; end
            2: begin ox = w / 8;            oy = h - h / 8 - SIDE; end
            3: begin ox = w - w / 8 - SIDE; oy = h - h / 8 - SIDE; end
            default: begin ox = w / 2 - SIDE / 2; oy = h / 2 - SIDE / 2; end
        endcase
        wx = (ox < 0) ? 0 : ox;
        wy = (oy < 0) ? 0 : oy;
        return (wx + SIDE <= w) && (wy + SIDE <= h);
    endfunction

    function automatic int windows_hit(input int x, input int y);
        int wx;
        int wy;
        int hits;
        hits = 0;
        for (int i = 0; i < WINDOW_COUNT; i++) begin
            if (window_place(i, wx, wy) && x >= wx && x < wx + SIDE &&
                y >= wy && y < wy + SIDE)
                hits++;
        end
        return hits;
    endfunction

    function automatic longint unsigned sat_add(input longint unsigned acc,
                                                input longint unsigned v,
                                                input longint unsigned cap);
        if (v >= cap || acc >= cap - v)
            return cap;
        return acc + v;
    endfunction

    function automatic logic [2:0] classify_frame();
        longint unsigned a;
        longint unsigned b;
        bit bright;
        bit flat;
        if (acc_pix == 0)
            return CLASS_NONE;
        bright = (20 * acc_lit >= acc_pix);
        a = acc_pix * acc_sq;
        b = acc_luma * acc_luma;
        flat = (a <= b) || (a - b < 36 * 65536 * acc_pix * acc_pix);
        if (bright && flat)
            return CLASS_FLAT;
        if (bright)
            return CLASS_IMAGE;
        if (100 * acc_lit < acc_pix)
            return CLASS_BLACK;
        return CLASS_DARK;
    endfunction

    function automatic void clear_sums();
        acc_lit  = 0;
        acc_pix  = 0;
        acc_luma = 0;
        acc_sq   = 0;
    endfunction

    // Fold one accepted pixel into the model; queue a result on a sampled end
    function automatic void account_pixel(input t_pixel p);
        int              hits;
        int unsigned     every;
        longint unsigned luma;
        longint unsigned sq;
        bit              lit;
        t_frame_stats    st;
        if (cfg_en) begin
            hits = windows_hit(int'(p.x), int'(p.y));
            luma = 77 * p.r + 150 * p.g + 29 * p.b;
            sq   = luma * luma;
            lit  = luma > cfg_thr * 256;
            for (int k = 0; k < hits; k++) begin
                acc_luma = sat_add(acc_luma, luma, CAP27);
                acc_sq   = sat_add(acc_sq, sq, CAP43);
                acc_pix  = sat_add(acc_pix, 1, CAP11);
                if (lit)
                    acc_lit = sat_add(acc_lit, 1, CAP11);
            end
        end
        if (!p.last)
            return;
        frames_ended++;
        if (!cfg_en) begin
            clear_sums();
            return;
        end
        frame_count = frame_count + 1;
        every = (cfg_every == 0) ? 1 : cfg_every;
        if (phase + 1 < every) begin
            phase = 16'(phase + 1);
            clear_sums();
            return;
        end
        phase = 0;
        st.frame_number      = frame_count;
        st.class_code        = classify_frame();
        st.lit_count         = acc_lit[10:0];
        st.pixel_count       = acc_pix[10:0];
        st.luma_total        = acc_luma[26:0];
        st.luma_square_total = acc_sq[42:0];
        stats_due.push_back(st);
        frames_sampled++;
        clear_sums();
    endfunction

    function automatic t_pixel px(input int x, input int y, input int r, input int g,
                                  input int b, input bit last);
        t_pixel p;
        p.x    = 12'(x);
        p.y    = 12'(y);
        p.r    = 8'(r);
        p.g    = 8'(g);
        p.b    = 8'(b);
        p.last = last;
        return p;
    endfunction

    // Offer one pixel, wait for its acceptance, then maybe idle a burst
    task automatic send_pixel(input t_pixel p);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.b, p.g, p.r, p.y, p.x};
        s_axis_tlast  <= p.last;
        pix_offered = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        account_pixel(p);
        pixels_sent++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            pix_offered = 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Drop the stream and let the block drain before touching registers
    task automatic settle();
        if (pix_offered) begin
            s_axis_tvalid <= 1'b0;
            pix_offered = 1'b0;
        end
        while (stats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[15:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_ENABLE:        cfg_en    = value[0];
            REG_SAMPLE_EVERY:  cfg_every = value[15:0];
            REG_FRAME_WIDTH:   cfg_w     = value[DIM_W-1:0];
            REG_FRAME_HEIGHT:  cfg_h     = value[DIM_W-1:0];
            REG_LIT_THRESHOLD: cfg_thr   = value[7:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int en, input int every, input int w, input int h,
                             input int thr);
        settle();
        write_reg(REG_ENABLE, en);
        write_reg(REG_SAMPLE_EVERY, every);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_LIT_THRESHOLD, thr);
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 9))
            0:       return 4096;
            1:       return $urandom_range(1, 4096);
            2:       return $urandom_range(1, 15);
            default: return $urandom_range(16, 80);
        endcase
    endfunction

    task automatic random_setup();
        int every;
        int thr;
        case ($urandom_range(0, 9))
            0:       every = 0;
            1:       every = 65535;
            2:       every = $urandom_range(4, 200);
            default: every = $urandom_range(1, 3);
        endcase
        case ($urandom_range(0, 7))
            0:       thr = 0;
            1:       thr = 255;
            default: thr = $urandom_range(0, 255);
        endcase
        configure($urandom_range(0, 9) != 0, every, pick_dim(), pick_dim(), thr);
    endtask

    // One frame: pixels aimed at the windows, some noise, tlast on the last.
    // Moods: 0 black, 1 one lit pixel, 2 random image, 3 near-constant, 4 noise.
    task automatic send_frame(input int len, input int mood);
        int x;
        int y;
        int wx;
        int wy;
        int lit_at;
        int base_r;
        int base_g;
        int base_b;
        t_pixel p;
        lit_at = $urandom_range(0, len - 1);
        base_r = $urandom_range(100, 255);
        base_g = $urandom_range(100, 254);
        base_b = $urandom_range(100, 255);
        for (int k = 0; k < len; k++) begin
            if (mood == 4 || $urandom_range(0, 9) == 0) begin
                x = $urandom_range(0, 4095);
                y = $urandom_range(0, 4095);
            end else begin
                void'(window_place($urandom_range(0, WINDOW_COUNT - 1), wx, wy));
                x = wx + $urandom_range(0, SIDE + 3) - 2;
                y = wy + $urandom_range(0, SIDE + 3) - 2;
                x = (x < 0) ? 0 : ((x > 4095) ? 4095 : x);
                y = (y < 0) ? 0 : ((y > 4095) ? 4095 : y);
            end
            case (mood)
                0: p = px(x, y, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), 0);
                1: p = (k == lit_at) ? px(x, y, 255, 255, 255, 0)
                                     : px(x, y, $urandom_range(0, 8),
                                          $urandom_range(0, 8), $urandom_range(0, 8), 0);
                3: p = px(x, y, base_r, base_g + $urandom_range(0, 1), base_b, 0);
                default: p = px(x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255), 0);
            endcase
            p.last = (k == len - 1);
            send_pixel(p);
        end
    endtask

    // Disabled after reset: frames are ignored; then a first sampled frame
    task automatic test_reset_state();
        send_pixel(px(240, 135, 255, 255, 255, 0));
        send_pixel(px(4095, 4095, 255, 255, 255, 1));
        configure(1, 1, 20, 20, 32);
        send_pixel(px(2, 2, 0, 0, 0, 0));
        send_pixel(px(17, 17, 255, 255, 255, 0));
        send_pixel(px(9, 9, 128, 64, 32, 0));
        send_pixel(px(4095, 4095, 255, 255, 255, 1));
        // corner pixel sits outside every window: nothing read
        send_pixel(px(0, 0, 0, 0, 0, 1));
    endtask

    // Enable dropped mid-frame and on a frame end
    task automatic test_enable_toggle();
        send_pixel(px(5, 5, 200, 200, 200, 0));
        settle();
        write_reg(REG_ENABLE, 0);
        send_pixel(px(6, 6, 10, 10, 10, 0));
        settle();
        write_reg(REG_ENABLE, 1);
        send_pixel(px(7, 7, 200, 190, 200, 1));
        settle();
        write_reg(REG_ENABLE, 0);
        send_pixel(px(8, 8, 200, 200, 200, 1));
        settle();
        write_reg(REG_ENABLE, 1);
        send_pixel(px(0, 0, 255, 255, 255, 1));
    endtask

    // Period zero samples every frame; a lowered period samples at once
    task automatic test_sample_period();
        configure(1, 0, 20, 20, 32);
        send_pixel(px(3, 3, 255, 0, 0, 1));
        send_pixel(px(3, 3, 0, 255, 0, 1));
        configure(1, 4, 20, 20, 32);
        repeat (3) send_pixel(px(4, 4, 0, 0, 255, 1));
        configure(1, 2, 20, 20, 32);
        send_pixel(px(4, 4, 90, 90, 90, 1));
    endtask

    // Zero width, largest frame, threshold extremes
    task automatic test_geometry();
        configure(1, 1, 0, 20, 32);
        send_pixel(px(0, 0, 255, 255, 255, 1));
        configure(1, 1, 4096, 4096, 255);
        send_pixel(px(512, 512, 255, 255, 255, 0));
        send_pixel(px(2040, 2040, 255, 255, 255, 0));
        send_pixel(px(3568, 3568, 255, 255, 255, 0));
        send_pixel(px(4095, 4095, 255, 255, 255, 1));
        configure(1, 1, 4096, 4096, 0);
        send_pixel(px(512, 3568, 0, 0, 1, 1));
    endtask

    // Five stacked windows: a long bright frame saturates every sum
    task automatic test_saturation();
        configure(1, 1, 20, 20, 0);
        for (int k = 0; k < 420; k++)
            send_pixel(px($urandom_range(2, 17), $urandom_range(2, 17),
                          $urandom_range(250, 255), 255, $urandom_range(250, 255),
                          k == 419));
    endtask

    // Hold the output while short sampled frames keep arriving
    task automatic test_output_hold();
        configure(1, 1, 20, 20, 32);
        hold_req = 1'b1;
        repeat (30) send_frame(3, 2);
    endtask

    task automatic test_random_frames();
        int mood;
        int len;
        random_setup();
        while (pixels_sent < RANDOM_UNTIL) begin
            if ($urandom_range(0, 3) == 0)
                random_setup();
            idle_on = ($urandom_range(0, 3) != 0);
            mood = $urandom_range(0, 4);
            len  = (mood == 1) ? $urandom_range(25, 40) : $urandom_range(4, 40);
            send_frame(len, mood);
        end
    endtask

    // Full rate on both sides to close the run
    task automatic test_steady_stream();
        int stop_at;
        idle_on = 1'b0;
        configure(1, 1, 48, 40, 40);
        stop_at = pixels_sent + QUIET_ITEMS;
        while (pixels_sent < stop_at)
            send_frame($urandom_range(4, 30), $urandom_range(0, 3));
    endtask

    // Result receiver: random stalls, plus one long hold on request
    initial begin : result_sink
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each accepted result with the oldest pending frame
    always @(posedge i_clk) begin : result_check
        t_frame_stats want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (stats_due.size() == 0) begin
                $error("result with no frame pending: frame_number %0d",
                       m_axis_tdata[31:0]);
                fail_count++;
            end else begin
                want = stats_due.pop_front();
                check_field("frame_number", want.frame_number, m_axis_tdata[31:0]);
                check_field("class_code", want.class_code, m_axis_tuser);
                check_field("lit_count", want.lit_count, m_axis_tdata[42:32]);
                check_field("pixel_count", want.pixel_count, m_axis_tdata[53:43]);
                check_field("luma_total", want.luma_total, m_axis_tdata[80:54]);
                check_field("luma_square_total", want.luma_square_total,
                            m_axis_tdata[123:81]);
                stats_checked++;
                if (want.class_code <= CLASS_NONE)
                    class_seen[want.class_code]++;
            end
        end
    end

    initial begin : run_limit
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : run_tests
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        cfg_en    = 1'b0;
        cfg_every = RST_SAMPLE_EVERY;
        cfg_w     = RST_FRAME_WIDTH;
        cfg_h     = RST_FRAME_HEIGHT;
        cfg_thr   = RST_LIT_THRESHOLD;
        phase       = '0;
        frame_count = '0;
        clear_sums();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        test_reset_state();
        test_enable_toggle();
        test_sample_period();
        test_geometry();
        test_saturation();
        test_output_hold();
        test_random_frames();
        test_steady_stream();
        settle();

        $display("sent %0d pixels over %0d frame ends, checked %0d classified frames",
                 pixels_sent, frames_ended, stats_checked);
        $display("classes: black %0d, dark %0d, image %0d, flat %0d, unread %0d",
                 class_seen[CLASS_BLACK], class_seen[CLASS_DARK], class_seen[CLASS_IMAGE],
                 class_seen[CLASS_FLAT], class_seen[CLASS_NONE]);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== frame_content_classifier.f =====
design/fcc_pkg.sv
design/fcc_cfg_regs.sv
design/fcc_ctrl.sv
design/fcc_dpath.sv
design/frame_content_classifier.sv
test/tb_frame_content_classifier.sv
